/* sv/lfpw_pkg.sv */
// Package for the page-organised pixel writer: payload structs, codes and
// controller/datapath command and status structs. No dependencies.
package lfpw_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic       A0_DATA      = 1'b1;
  localparam logic       A0_CMD       = 1'b0;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  localparam logic [1:0] SEL_PAGE = 2'd0;
  localparam logic [1:0] SEL_COLH = 2'd1;
  localparam logic [1:0] SEL_COLL = 2'd2;
  localparam logic [1:0] SEL_DATA = 2'd3;

  typedef struct packed {
    logic [1:0] draw_mode;
    logic [7:0] pixel_row;
    logic [7:0] pixel_column;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last_byte;
  } link_res_t;

  typedef struct packed {
    logic       capture;
    logic       rd;
    logic       wr;
    logic       clr;
    logic       emit;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic clr_done;
  } dp_stat_t;

endpackage

/* sv/lfpw_datapath.sv */
// Datapath of the pixel writer: request register, frame store, byte
// update and output register. Depends on lfpw_pkg.
module lfpw_datapath import lfpw_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pix_req_t  req_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output logic      strobe_o,
  output link_res_t res_o
);

  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int PAGE_W = (PANEL_HEIGHT > 8) ? $clog2(PANEL_HEIGHT / 8) : 1;
  localparam int ADDR_W = PAGE_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [7:0]        mem [DEPTH];
  pix_req_t          req_q;
  logic [7:0]        rd_q;
  logic [7:0]        nb_q;
  logic [7:0]        nb_d;
  logic [7:0]        mask;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              strobe_q;
  link_res_t         res_q;
  link_res_t         res_d;

  assign stat_o.hit = ({1'b0, req_i.pixel_row} < 9'(PANEL_HEIGHT)) &&
                      ({1'b0, req_i.pixel_column} < 9'(PANEL_WIDTH));
  assign stat_o.clr_done = (clr_cnt_q == {ADDR_W{1'b1}});

  assign mask = 8'b1 << req_q.pixel_row[2:0];

  always_comb begin
    case (req_q.draw_mode)
      MODE_SET:    nb_d = rd_q | mask;
      MODE_CLEAR:  nb_d = rd_q & ~mask;
      MODE_INVERT: nb_d = rd_q ^ mask;
      default:     nb_d = rd_q;
    endcase
  end

  always_comb begin
    res_d = '0;
    case (cmd_i.sel)
      SEL_PAGE: begin
        res_d.link_byte = CMD_PAGE + 8'(req_i.pixel_row[7:3]);
        res_d.is_data   = A0_CMD;
      end
      SEL_COLH: begin
        res_d.link_byte = CMD_COL_HIGH + 8'(req_q.pixel_column[7:4]);
        res_d.is_data   = A0_CMD;
      end
      SEL_COLL: begin
        res_d.link_byte = 8'(req_q.pixel_column[3:0]);
        res_d.is_data   = A0_CMD;
      end
      SEL_DATA: begin
        res_d.link_byte = nb_q;
        res_d.is_data   = A0_DATA;
        res_d.last_byte = 1'b1;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_i;
      addr_q <= {req_i.pixel_row[3 +: PAGE_W], req_i.pixel_column[COL_W-1:0]};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[{req_i.pixel_row[3 +: PAGE_W], req_i.pixel_column[COL_W-1:0]}];
    end
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (cmd_i.wr) begin
      mem[addr_q] <= nb_d;
    end
    if (cmd_i.wr) begin
      nb_q <= nb_d;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

/* sv/lfpw_ctrl.sv */
// Controller of the pixel writer: clearing pass, request intake and the
// four-byte emit sequence. Depends on lfpw_pkg.
module lfpw_ctrl import lfpw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_B1   = 3'd2;
  localparam logic [2:0] ST_B2   = 3'd3;
  localparam logic [2:0] ST_B3   = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && stat_i.hit) begin
          cmd_o.capture = 1'b1;
          cmd_o.rd      = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = SEL_PAGE;
          state_d       = ST_B1;
        end
      end
      ST_B1: begin
        cmd_o.wr   = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_COLH;
        state_d    = ST_B2;
      end
      ST_B2: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_COLL;
        state_d    = ST_B3;
      end
      ST_B3: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_DATA;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

/* sv/lcd_framebuffer_pixel_writer.sv */
// Top level of the page-organised panel pixel writer with shadow frame store.
// Depends on lfpw_pkg, lfpw_ctrl and lfpw_datapath.
//
//   channel   handshake          payload
//   request   start & !busy      req_i  (pix_req_t)
//   result    strobe_o           res_o  (link_res_t)
//
// An on-panel request reads the store at intake, then the emit sequencer
// sends the page, column-high, column-low and data link bytes in turn;
// results follow the intake edge on consecutive cycles. Off-panel requests give no output.
// After reset the store is cleared one entry a cycle, 1024 entries at the
// default panel size, with busy high. Results cannot be held off.
module lcd_framebuffer_pixel_writer import lfpw_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pix_req_t  req_i,
  output logic      strobe_o,
  output link_res_t res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lfpw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  lfpw_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

`ifndef SYNTHESIS
  a_hit_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && ({1'b0, req_i.pixel_row} < 9'(PANEL_HEIGHT)) &&
    ({1'b0, req_i.pixel_column} < 9'(PANEL_WIDTH))
    |=> strobe_o && !res_o.is_data && !res_o.last_byte)
    else $error("on-panel request did not start a transfer run");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.last_byte |=> strobe_o)
    else $error("transfer run broken before data byte");

  a_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.last_byte
    |-> res_o.is_data && $past(strobe_o, 1) && $past(strobe_o, 2) && $past(strobe_o, 3))
    else $error("data byte not preceded by three command transfers");
`endif

endmodule
